>>> design/msfr_pkg.sv
// ----------------------------------------------------------------------------
// msfr_pkg
// Types and constants shared by the multidrop slave frame receiver modules.
// ----------------------------------------------------------------------------
package msfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 3;

  localparam logic [ByteW-1:0] CodeGood = 8'h0f;
  localparam logic [ByteW-1:0] CodeBad  = 8'hf0;

  typedef enum logic [1:0] {
    PH_ADDR  = 2'd0,
    PH_LEN   = 2'd1,
    PH_DATA  = 2'd2,
    PH_CHECK = 2'd3
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_ACK     = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_GOOD    = 3'd2,
    KIND_BAD     = 3'd3,
    KIND_ABORT   = 3'd4
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             ninth_bit;
  } char_t;

  typedef struct packed {
    kind_e            kind;
    logic             transmit;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] byte_index;
  } result_t;

endpackage

>>> design/msfr_in_stage.sv
// ----------------------------------------------------------------------------
// msfr_in_stage
// Input register holding one received character until the frame logic
// consumes it.
// ----------------------------------------------------------------------------
module msfr_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  msfr_pkg::char_t in_char_i,
  input  logic           advance_i,
  output logic           in_stall_o,
  output logic           char_valid_o,
  output msfr_pkg::char_t char_o
);
  import msfr_pkg::*;

  logic  valid_q, valid_d;
  char_t char_q;
  logic  accept;

  // The held character blocks a new one only if it cannot move on this cycle.
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= in_char_i;
    end
  end

  assign char_valid_o = valid_q;
  assign char_o       = char_q;

endmodule

>>> design/msfr_frame_fsm.sv
// ----------------------------------------------------------------------------
// msfr_frame_fsm
// Frame state machine: address match, length, payload and check byte.
// ----------------------------------------------------------------------------
module msfr_frame_fsm (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  msfr_pkg::char_t          char_i,
  input  logic [msfr_pkg::ByteW-1:0] station_address_i,
  output logic                     res_valid_o,
  output msfr_pkg::result_t        res_o
);
  import msfr_pkg::*;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0] chk_q, chk_d;
  logic [ByteW-1:0] cnt_inc;
  logic [ByteW-1:0] chk_next;
  logic             addr_match;

  assign cnt_inc    = cnt_q + 8'd1;
  assign chk_next   = chk_q ^ char_i.rx_byte;
  assign addr_match = char_i.ninth_bit && (char_i.rx_byte == station_address_i);

  // Next state.
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    chk_d   = chk_q;
    if (fire_i) begin
      case (phase_q)
        PH_ADDR: begin
          if (addr_match) begin
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          if (char_i.ninth_bit) begin
            phase_d = PH_ADDR;
          end else begin
            len_d   = char_i.rx_byte;
            cnt_d   = '0;
            chk_d   = char_i.rx_byte;
            phase_d = (char_i.rx_byte == '0) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          if (char_i.ninth_bit) begin
            phase_d = PH_ADDR;
          end else begin
            cnt_d = cnt_inc;
            chk_d = chk_next;
            if (cnt_inc == len_q) begin
              phase_d = PH_CHECK;
            end
          end
        end
        PH_CHECK: begin
          if (char_i.ninth_bit) begin
            phase_d = PH_ADDR;
          end else if (chk_next == '0) begin
            phase_d = PH_ADDR;
          end else begin
            phase_d = PH_LEN;
          end
        end
        default: phase_d = PH_ADDR;
      endcase
    end
  end

  // Result for the character being consumed.
  always_comb begin
    res_valid_o      = 1'b0;
    res_o.kind       = KIND_ABORT;
    res_o.transmit   = 1'b0;
    res_o.data_byte  = '0;
    res_o.byte_index = '0;
    if (fire_i) begin
      case (phase_q)
        PH_ADDR: begin
          if (addr_match) begin
            res_valid_o     = 1'b1;
            res_o.kind      = KIND_ACK;
            res_o.transmit  = 1'b1;
            res_o.data_byte = char_i.rx_byte;
          end
        end
        PH_LEN: begin
          res_valid_o = char_i.ninth_bit;
        end
        PH_DATA: begin
          res_valid_o = 1'b1;
          if (!char_i.ninth_bit) begin
            res_o.kind       = KIND_PAYLOAD;
            res_o.data_byte  = char_i.rx_byte;
            res_o.byte_index = cnt_q;
          end
        end
        PH_CHECK: begin
          res_valid_o = 1'b1;
          if (!char_i.ninth_bit) begin
            res_o.transmit = 1'b1;
            if (chk_next == '0) begin
              res_o.kind      = KIND_GOOD;
              res_o.data_byte = CodeGood;
            end else begin
              res_o.kind      = KIND_BAD;
              res_o.data_byte = CodeBad;
            end
          end
        end
        default: res_valid_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ADDR;
      len_q   <= '0;
      cnt_q   <= '0;
      chk_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      chk_q   <= chk_d;
    end
  end

`ifndef SYNTH
  // In the payload phase the count never reaches the announced length.
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (len_q != '0 && cnt_q != len_q))
    else $error("payload phase with count at length");

  // An address character inside a message always returns to address waiting.
  a_abort_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && char_i.ninth_bit && phase_q != PH_ADDR) |=> (phase_q == PH_ADDR))
    else $error("abort did not return to address phase");

  // A payload result carries the count as its index, and the count then advances by one.
  a_payload_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_PAYLOAD) |=> (cnt_q == $past(cnt_q) + 8'd1))
    else $error("payload count did not advance");
`endif

endmodule

>>> design/msfr_out_stage.sv
// ----------------------------------------------------------------------------
// msfr_out_stage
// Result register with its valid flag, loaded when the frame logic emits.
// ----------------------------------------------------------------------------
module msfr_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  msfr_pkg::result_t res_i,
  input  logic              out_stall_i,
  output logic              advance_o,
  output logic              out_valid_o,
  output msfr_pkg::result_t res_o
);
  import msfr_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // The register can take a new beat when empty or when its beat leaves now.
  assign advance_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> design/multidrop_slave_frame_receiver.sv
// ----------------------------------------------------------------------------
// multidrop_slave_frame_receiver
// Slave receiver for a nine-bit multidrop link: address match, length,
// payload delivery and XOR check with acknowledge and status bytes.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+-----------------------------------------
//  config   | cfg_we_i                 | cfg_station_address_i
//  input    | in_valid_i, in_stall_o   | rx_byte_i, ninth_bit_i
//  output   | out_valid_o, out_stall_i | result_kind_o, transmit_o, data_byte_o,
//           |                          | byte_index_o
//
// One character is accepted per cycle while in_stall_o is low. It is held in the
// input register, and its result, if any, is then loaded into the result
// register, from which it is presented on the outputs.
// Characters that cause no result are simply consumed by the frame logic.
// Reset empties both registers and returns to waiting for the own address.
// A stall on the output holds the result register and, once the input
// register is full, stalls the input in the same cycle.
module multidrop_slave_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_station_address_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       ninth_bit_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] result_kind_o,
  output logic       transmit_o,
  output logic [7:0] data_byte_o,
  output logic [7:0] byte_index_o
);
  import msfr_pkg::*;

  logic [ByteW-1:0] station_q;
  char_t            in_char;
  char_t            held_char;
  logic             held_valid;
  logic             advance;
  logic             fire;
  logic             res_valid;
  result_t          res;
  result_t          out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= '0;
    end else if (cfg_we_i) begin
      station_q <= cfg_station_address_i;
    end
  end

  assign in_char.rx_byte   = rx_byte_i;
  assign in_char.ninth_bit = ninth_bit_i;

  msfr_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_char_i    (in_char),
    .advance_i    (advance),
    .in_stall_o   (in_stall_o),
    .char_valid_o (held_valid),
    .char_o       (held_char)
  );

  assign fire = held_valid && advance;

  msfr_frame_fsm u_frame_fsm (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (fire),
    .char_i            (held_char),
    .station_address_i (station_q),
    .res_valid_o       (res_valid),
    .res_o             (res)
  );

  msfr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign result_kind_o = out_res.kind;
  assign transmit_o    = out_res.transmit;
  assign data_byte_o   = out_res.data_byte;
  assign byte_index_o  = out_res.byte_index;

endmodule
